>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPCA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppca assertion failed");

// next-cycle implication
`define PPCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppca assertion failed");

`endif

>>> sv/ppca_pkg.sv
// ----------------------------------------------------------------------------
// ppca_pkg
// widths, constants, cordic angle table and controller/datapath types
// ----------------------------------------------------------------------------
package ppca_pkg;

  localparam int POS_W        = 32;
  localparam int ANG_W        = 16;
  localparam int COST_W       = 48;
  localparam int QUAT_W       = 16;
  localparam int PROD_W       = 2 * QUAT_W;
  localparam int TERM_W       = PROD_W + 2;
  localparam int ONE_SHIFT    = 2 * (QUAT_W - 2);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORD_W       = 38;
  localparam int ZACC_W       = 32;
  localparam int GAIN_W       = 32;
  localparam int HI_W         = CORD_W - GAIN_W;
  localparam int DIST_W       = CORD_W + 1;
  localparam int TURN_W       = ANG_W + 19;
  localparam int DIFF_W       = POS_W + 1;

  localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;

  // atan(2^-i), full turn = 2^32
  function automatic logic [ZACC_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ZACC_W-1:0] v;
    case (idx)
      4'd0:    v = 32'h2000_0000;
      4'd1:    v = 32'h12E4_051E;
      4'd2:    v = 32'h09FB_385B;
      4'd3:    v = 32'h0511_11D4;
      4'd4:    v = 32'h028B_0D43;
      4'd5:    v = 32'h0145_D7E1;
      4'd6:    v = 32'h00A2_F61E;
      4'd7:    v = 32'h0051_7C55;
      4'd8:    v = 32'h0028_BE53;
      4'd9:    v = 32'h0014_5F2F;
      4'd10:   v = 32'h000A_2F98;
      4'd11:   v = 32'h0005_17CC;
      4'd12:   v = 32'h0002_8BE6;
      4'd13:   v = 32'h0001_45F3;
      4'd14:   v = 32'h0000_A2FA;
      4'd15:   v = 32'h0000_517D;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_YLOAD, ST_YAW, ST_YTAKE,
    ST_DLOAD, ST_DIST, ST_SCALE, ST_DSUM, ST_ACC, ST_DONE
  } ppca_state_t;

  typedef struct packed {
    logic              ld_in;
    logic              mul;
    logic              sum;
    logic              ld_yaw;
    logic              ld_dist;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              yaw_take;
    logic              scale;
    logic              dsum;
    logic              acc;
    logic              out_load;
  } ppca_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic out_full;
  } ppca_stat_t;

endpackage

>>> sv/ppca_dp.sv
// ----------------------------------------------------------------------------
// ppca_dp
// pose registers, quaternion products, shared cordic unit, scaling and total
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppca_dp import ppca_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppca_cmd_t                cmd,
  output ppca_stat_t               stat,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [QUAT_W-1:0] in_quat_x,
  input  logic signed [QUAT_W-1:0] in_quat_y,
  input  logic signed [QUAT_W-1:0] in_quat_z,
  input  logic signed [QUAT_W-1:0] in_quat_w,
  input  logic                     in_first_pose,
  input  logic                     in_last_pose,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [COST_W-1:0]        out_path_cost
);

  logic signed [POS_W-1:0]  px_r, py_r;
  logic signed [QUAT_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic                     first_r, last_r;
  logic signed [PROD_W-1:0] wz_r, xy_r, yy_r, zz_r;
  logic [TERM_W-1:0]        num_r, den_r;
  logic                     vzero_r;
  logic signed [CORD_W-1:0] cx_r, cy_r;
  logic [ZACC_W-1:0]        cz_r;
  logic [ANG_W-1:0]         yaw_r;
  logic [2*GAIN_W-1:0]      lo_prod_r;
  logic [HI_W-1:0]          hi_r;
  logic [DIST_W-1:0]        dist_r;
  logic [TURN_W-1:0]        turn_r;
  logic [POS_W-1:0]         prev_x_r, prev_y_r;
  logic [ANG_W-1:0]         prev_yaw_r;
  logic [COST_W-1:0]        total_r;
  logic                     out_valid_r;
  logic [COST_W-1:0]        out_cost_r;

  logic [TERM_W-1:0]        num_nxt, den_nxt;
  logic signed [CORD_W-1:0] ld_x, ld_y, sx, sy;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        adx, ady;
  logic [ZACC_W-1:0]        z_rnd;
  logic [2*GAIN_W-1:0]      lo_rnd;
  logic [DIST_W-1:0]        dist_nxt;
  logic [ANG_W-1:0]         dyaw, dyaw_abs;
  logic [TURN_W-1:0]        turn_nxt;
  logic [COST_W:0]          sum_tot;

  always_comb begin
    num_nxt = ({{2{wz_r[PROD_W-1]}}, wz_r} + {{2{xy_r[PROD_W-1]}}, xy_r}) << 1;
    den_nxt = (TERM_W'(1) << ONE_SHIFT) - (({2'b00, yy_r} + {2'b00, zz_r}) << 1);
    ld_x    = CORD_W'($signed(den_r));
    ld_y    = CORD_W'($signed(num_r));
    dx      = $signed({px_r[POS_W-1], px_r}) - $signed({prev_x_r[POS_W-1], prev_x_r});
    dy      = $signed({py_r[POS_W-1], py_r}) - $signed({prev_y_r[POS_W-1], prev_y_r});
    adx     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sx      = cx_r >>> cmd.step_idx;
    sy      = cy_r >>> cmd.step_idx;
    z_rnd   = cz_r + (ZACC_W'(1) << (ZACC_W - ANG_W - 1));
    lo_rnd  = lo_prod_r + ((2*GAIN_W)'(1) << (GAIN_W - 1));
    dist_nxt = DIST_W'(hi_r) * DIST_W'(INV_GAIN) + DIST_W'(lo_rnd[2*GAIN_W-1:GAIN_W]);
    dyaw     = yaw_r - prev_yaw_r;
    // fold to the short way round, a half turn stays a half turn
    dyaw_abs = (dyaw > (ANG_W'(1) << (ANG_W - 1))) ? ANG_W'(-dyaw) : dyaw;
    turn_nxt = ((TURN_W'(dyaw_abs) << 18) + (TURN_W'(1) << (ANG_W - 1))) >> ANG_W;
    sum_tot  = {1'b0, total_r} + (COST_W + 1)'(dist_r) + (COST_W + 1)'(turn_r);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      qx_r    <= in_quat_x;
      qy_r    <= in_quat_y;
      qz_r    <= in_quat_z;
      qw_r    <= in_quat_w;
      first_r <= in_first_pose;
      last_r  <= in_last_pose;
    end
    if (cmd.mul) begin
      wz_r <= qw_r * qz_r;
      xy_r <= qx_r * qy_r;
      yy_r <= qy_r * qy_r;
      zz_r <= qz_r * qz_r;
    end
    if (cmd.sum) begin
      num_r   <= num_nxt;
      den_r   <= den_nxt;
      vzero_r <= (num_nxt == '0) && (den_nxt == '0);
    end
    if (cmd.ld_yaw) begin
      if (ld_x < 0) begin
        cx_r <= -ld_x;
        cy_r <= -ld_y;
        cz_r <= ZACC_W'(1) << (ZACC_W - 1);
      end else begin
        cx_r <= ld_x;
        cy_r <= ld_y;
        cz_r <= '0;
      end
    end else if (cmd.ld_dist) begin
      cx_r <= $signed(CORD_W'(adx));
      cy_r <= $signed(CORD_W'(ady));
      cz_r <= '0;
    end else if (cmd.step) begin
      if (!cy_r[CORD_W-1]) begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + atan_lut(cmd.step_idx);
      end else begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - atan_lut(cmd.step_idx);
      end
    end
    if (cmd.yaw_take) begin
      yaw_r <= vzero_r ? '0 : z_rnd[ZACC_W-1:ZACC_W-ANG_W];
    end
    if (cmd.scale) begin
      lo_prod_r <= (2*GAIN_W)'(cx_r[GAIN_W-1:0]) * (2*GAIN_W)'(INV_GAIN);
      hi_r      <= cx_r[CORD_W-1:GAIN_W];
    end
    if (cmd.dsum) begin
      dist_r <= dist_nxt;
      turn_r <= turn_nxt;
    end
    if (cmd.out_load) begin
      out_cost_r <= total_r;
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_yaw_r <= '0;
      total_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        prev_x_r   <= px_r;
        prev_y_r   <= py_r;
        prev_yaw_r <= yaw_r;
        if (first_r) begin
          total_r <= '0;
        end else if (sum_tot[COST_W]) begin
          total_r <= '1;
        end else begin
          total_r <= sum_tot[COST_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.first    = first_r;
  assign stat.last     = last_r;
  assign stat.out_full = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_path_cost = out_cost_r;

  `PPCA_ASSERT_NEXT(a_total_grows, cmd.acc && !first_r, total_r >= $past(total_r))
  `PPCA_ASSERT_IMPL(a_mag_nonneg, cmd.scale, !cx_r[CORD_W-1])

endmodule

>>> sv/ppca_ctrl.sv
// ----------------------------------------------------------------------------
// ppca_ctrl
// sequencer for the yaw pass, the distance pass and the accumulate steps
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppca_ctrl import ppca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output ppca_cmd_t  cmd,
  input  ppca_stat_t stat
);

  ppca_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.step_idx = cnt_r;
    in_stall     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_YLOAD;
      end
      ST_YLOAD: begin
        cmd.ld_yaw = 1'b1;
        state_nxt  = ST_YAW;
      end
      ST_YAW: begin
        cmd.step = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_YTAKE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_YTAKE: begin
        cmd.yaw_take = 1'b1;
        state_nxt    = stat.first ? ST_ACC : ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.ld_dist = 1'b1;
        state_nxt   = ST_DIST;
      end
      ST_DIST: begin
        cmd.step = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DSUM;
      end
      ST_DSUM: begin
        cmd.dsum  = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PPCA_ASSERT_IMPL(a_no_overrun, cmd.out_load, !stat.out_full)
  `PPCA_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_MUL)
  `PPCA_ASSERT_IMPL(a_cnt_idle, state_r == ST_IDLE, cnt_r == '0)

endmodule

>>> sv/path_pose_cost_accumulator.sv
// ----------------------------------------------------------------------------
// path_pose_cost_accumulator
// path length plus heading change cost, one pose per transaction
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | pos_x, pos_y, quat_x..w, first/last
//  out_    | output    | out_valid / out_stall | path_cost (unsigned q32.16)
//
//  a pose runs two 16-step passes of the single shared cordic unit (only the
//  yaw pass when marked first) plus product, scale and add steps
//  one pose is in flight at a time; in_stall is low only when idle
//  a finished total sits in the output register so the next pose is taken
//  while out_stall holds it; only a second total waits for it to drain
//  reset (rst_n low, synchronous) clears previous pose, heading and total
// ----------------------------------------------------------------------------
module path_pose_cost_accumulator import ppca_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // pose transactions
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [QUAT_W-1:0] in_quat_x,
  input  logic signed [QUAT_W-1:0] in_quat_y,
  input  logic signed [QUAT_W-1:0] in_quat_z,
  input  logic signed [QUAT_W-1:0] in_quat_w,
  input  logic                     in_first_pose,
  input  logic                     in_last_pose,
  // total transactions
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COST_W-1:0]        out_path_cost
);

  // command and status between sequencer and datapath
  ppca_cmd_t  cmd;
  ppca_stat_t stat;

  // sequencer: yaw pass, distance pass (skipped on a first pose), accumulate
  ppca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: quaternion terms, cordic, gain correction, saturating total
  ppca_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_quat_x     (in_quat_x),
    .in_quat_y     (in_quat_y),
    .in_quat_z     (in_quat_z),
    .in_quat_w     (in_quat_w),
    .in_first_pose (in_first_pose),
    .in_last_pose  (in_last_pose),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_path_cost (out_path_cost)
  );

endmodule
